@@ hw/rtl/itoa_pkg.sv @@
package itoa_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int DIGIT_COUNT = 20;
   localparam int BCD_WIDTH = 4 * DIGIT_COUNT;
   localparam int CNT_WIDTH = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
   localparam int NDIG_WIDTH = 5;

   localparam logic [7:0] ASCII_ZERO = 8'd48;
   localparam logic [7:0] ASCII_MINUS = 8'd45;
   localparam logic [3:0] BCD_FIVE = 4'd5;
   localparam logic [3:0] BCD_BIAS = 4'd3;

   typedef struct packed {
      logic [63:0] value_bits;
      logic        mode;
   } req_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic [4:0] text_length;
      logic       last_char;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_NORM,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic norm;
      logic fix_len;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic top_zero;
      logic multi_digit;
      logic neg;
      logic out_free;
   } status_type;

endpackage

@@ hw/rtl/integer_to_decimal_ascii.sv @@
// Channel   Direction  Handshake              Word
// req_      in         req_valid / req_stall  value_bits, mode
// rsp_      out        rsp_valid / rsp_stall  text_char, text_length, last_char
//
// Each value is loaded, then takes one shift-and-add-3 step per input bit,
// one step per leading zero digit skipped, a step to latch the length and
// one step per character, minus sign included, each waiting on a stalled output.
// The double-dabble loop takes the longest.
// Synchronous active-high reset clears the controller and the output valid.
// A stalled output holds its word and the character sequencer waits.
module integer_to_decimal_ascii
   import itoa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   itoa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hw/rtl/itoa_ctrl.sv @@
module itoa_ctrl
   import itoa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(VALUE_WIDTH - 1);

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) state_in = ST_NORM;
         end
         ST_NORM: begin
            if (!(status.top_zero && status.multi_digit)) begin
               state_in = status.neg ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (status.out_free) state_in = ST_DIGITS;
         end
         ST_DIGITS: begin
            if (status.out_free && !status.multi_digit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:    cmd.load = req_valid;
         ST_CONVERT: cmd.convert = 1'b1;
         ST_NORM: begin
            cmd.norm    = status.top_zero && status.multi_digit;
            cmd.fix_len = !(status.top_zero && status.multi_digit);
         end
         ST_SIGN:    cmd.emit_sign = status.out_free;
         ST_DIGITS:  cmd.emit_digit = status.out_free;
         default:    cmd = '0;
      endcase
   end

endmodule

@@ hw/rtl/itoa_dpath.sv @@
module itoa_dpath
   import itoa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]   bcd_adj;
   logic                   neg_ff, neg_in;
   logic [NDIG_WIDTH-1:0]  ndig_ff, ndig_in;
   logic [4:0]             len_ff, len_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [VALUE_WIDTH-1:0] raw;
   logic                   raw_neg;
   logic [3:0]             top_digit;

   assign raw       = req_data.value_bits[VALUE_WIDTH-1:0];
   assign raw_neg   = req_data.mode && raw[VALUE_WIDTH-1];
   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];

   // Add-3 correction on every BCD digit before the next shift.
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= BCD_FIVE) ?
                             bcd_ff[i*4 +: 4] + BCD_BIAS : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      neg_in  = neg_ff;
      ndig_in = ndig_ff;
      len_in  = len_ff;
      if (cmd.load) begin
         neg_in  = raw_neg;
         mag_in  = raw_neg ? (~raw + 1'b1) : raw;
         bcd_in  = '0;
         ndig_in = NDIG_WIDTH'(DIGIT_COUNT);
      end
      if (cmd.convert) begin
         bcd_in = {bcd_adj[BCD_WIDTH-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
      end
      if (cmd.norm || cmd.emit_digit) begin
         bcd_in  = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
         ndig_in = ndig_ff - 1'b1;
      end
      if (cmd.fix_len) begin
         len_in = ndig_ff + {4'd0, neg_ff};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit_sign) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.text_char   = ASCII_MINUS;
         rsp_data_in.text_length = len_ff;
         rsp_data_in.last_char   = 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.text_char   = ASCII_ZERO + {4'd0, top_digit};
         rsp_data_in.text_length = len_ff;
         rsp_data_in.last_char   = (ndig_ff == NDIG_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ndig_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         ndig_ff      <= ndig_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.top_zero    = (top_digit == 4'd0);
   assign status.multi_digit = (ndig_ff > NDIG_WIDTH'(1));
   assign status.neg         = neg_ff;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> !(rsp_valid_ff && rsp_stall))
      else $error("word emitted while the output register was still held");

   a_digit_left: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> (ndig_ff != '0))
      else $error("digit emitted with no digits left");

   a_neg_mode: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (!neg_ff || $past(req_data.mode)))
      else $error("negative flag set for an unsigned value");
`endif

endmodule

@@ verif/tb.sv @@
module tb;
   import itoa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 150;
   localparam int RANDOM_WORDS = 107;
   localparam logic [64:0] FULL_MASK = (65'd1 << VALUE_WIDTH) - 65'd1;
   localparam logic [63:0] VALUE_MASK = FULL_MASK[63:0];

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_words[$];
   rsp_type expected_chars[$];
   logic    req_taken = 1'b0;
   int      accepted_count = 0;
   int      checked_chars = 0;
   int      error_count = 0;
   int      cycle_count = 0;
   logic    calm;

   integer_to_decimal_ascii dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // Neither side idles while this window of words goes through.
   assign calm = (accepted_count >= 60) && (accepted_count < 95);

   function automatic void queue_decimal_text(input req_type word);
      logic [63:0] magnitude;
      logic        negative;
      logic [7:0]  digits_rev[20];
      int          ndig;
      int          total;
      int          pos;
      rsp_type     ch;
      magnitude = word.value_bits & VALUE_MASK;
      negative = word.mode && magnitude[VALUE_WIDTH-1];
      if (negative) begin
         magnitude = (~magnitude + 64'd1) & VALUE_MASK;
      end
      ndig = 0;
      do begin
         digits_rev[ndig] = ASCII_ZERO + 8'(magnitude % 64'd10);
         ndig++;
         magnitude = magnitude / 64'd10;
      end while (magnitude != 64'd0);
      total = ndig + int'(negative);
      for (int k = 0; k < total; k++) begin
         if (negative && k == 0) begin
            ch.text_char = ASCII_MINUS;
         end else begin
            pos = k - int'(negative);
            ch.text_char = digits_rev[ndig - 1 - pos];
         end
         ch.text_length = 5'(total);
         ch.last_char = (k == total - 1);
         expected_chars.push_back(ch);
      end
   endfunction

   function automatic void add_word(input logic [63:0] value, input logic mode);
      req_type word;
      word.value_bits = value;
      word.mode = mode;
      pending_words.push_back(word);
   endfunction

   task automatic report_mismatch(input string msg);
      // Only the first hundred mismatches are printed; all are counted.
      if (error_count < 100) begin
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      end
      error_count++;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
            req_data <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 33);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d characters still expected",
                  cycle_count, expected_chars.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin : watch_channels
      rsp_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         queue_decimal_text(req_data);
         accepted_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected word char=%0d length=%0d last=%0b",
                                      rsp_data.text_char, rsp_data.text_length,
                                      rsp_data.last_char));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.text_char !== want.text_char) begin
               report_mismatch($sformatf("text_char got %0d want %0d",
                                         rsp_data.text_char, want.text_char));
            end
            if (rsp_data.text_length !== want.text_length) begin
               report_mismatch($sformatf("text_length got %0d want %0d",
                                         rsp_data.text_length, want.text_length));
            end
            if (rsp_data.last_char !== want.last_char) begin
               report_mismatch($sformatf("last_char got %0b want %0b",
                                         rsp_data.last_char, want.last_char));
            end
            checked_chars++;
         end
      end
   end

   initial begin : stimulus
      logic [63:0] value;
      int          shape;
      // Extremes, zero in both modes, the most negative signed value and
      // the digit-count boundaries.
      add_word(64'd0, 1'b0);
      add_word(64'd0, 1'b1);
      add_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      add_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      add_word(64'h8000_0000_0000_0000, 1'b1);
      add_word(64'h8000_0000_0000_0000, 1'b0);
      add_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      add_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      add_word(64'h8000_0000_0000_0001, 1'b1);
      add_word(64'd1, 1'b0);
      add_word(64'd9, 1'b1);
      add_word(64'd10, 1'b0);
      add_word(64'd99, 1'b0);
      add_word(64'd100, 1'b1);
      add_word(-64'sd10, 1'b1);
      add_word(-64'sd9, 1'b1);
      add_word(64'd10000000000000000000, 1'b0);
      add_word(64'd9999999999999999999, 1'b0);
      add_word(64'd1000000000000000000, 1'b1);
      add_word(64'h0000_0000_FFFF_FFFF, 1'b0);
      add_word(64'hFFFF_FFFF_8000_0000, 1'b1);
      add_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      add_word(64'h5555_5555_5555_5555, 1'b0);

      // Random words spread over all text lengths in both modes.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         value = {$urandom, $urandom};
         shape = $urandom_range(4);
         case (shape)
            0: begin
               value = value >> $urandom_range(63);
            end
            1: begin
               value = 64'($urandom_range(1000));
            end
            2: begin
               value = -64'($urandom_range(100000, 1));
            end
            default: begin
            end
         endcase
         add_word(value, 1'($urandom_range(1)));
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d values in signed and unsigned modes, %0d characters checked.",
               accepted_count, checked_chars);
      $display("Texts ranged from a single zero to twenty characters, with random stalls.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ integer_to_decimal_ascii.f @@
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_ctrl.sv
hw/rtl/itoa_dpath.sv
hw/rtl/integer_to_decimal_ascii.sv
verif/tb.sv
